FILE: rtl/core/lav_pkg.sv
`default_nettype none
package lav_pkg;
   localparam int unsigned COORD_W = 24;
   localparam int unsigned COL_W = 18;
   localparam int unsigned SHIFT_W = 26;
   localparam int unsigned ROW_W = 2;
   localparam int unsigned MAG_W = 24;
   localparam int unsigned SUMSQ_W = 50;
   localparam int unsigned ROOT_W = 31;
   localparam int unsigned QUO_W = 21;

   localparam logic [ROW_W-1:0] ROW_SIDE = 2'd0;
   localparam logic [ROW_W-1:0] ROW_UP = 2'd1;
   localparam logic [ROW_W-1:0] ROW_FWD = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COL_W-1:0] col_type;
   typedef logic signed [COORD_W:0] vec_elem_type;
   typedef vec_elem_type [2:0] vec_type;
   typedef logic signed [QUO_W:0] unit_elem_type;
   typedef unit_elem_type [2:0] unit_type;
endpackage
`default_nettype wire

FILE: rtl/core/look_at_view_matrix.sv
`default_nettype none
// Look-at view matrix generator.
// Input: drive eye, target and up vectors (signed Q8.16) with start high; the
// transfer takes place at the rising edge where start is high and busy is low.
// busy is high after each transfer while the issue gate counts down, and no item
// is taken while busy is high; start may stay high for back-to-back items.
// Output: three rows (side, up, negated forward) on consecutive cycles, each
// marked by rsp_valid for one cycle, with rsp_last_row on the third.
// Path: forward normalizer, registered cross product, side normalizer, stage A,
// stage B and the row hold register, in that order. Each normalizer has a
// prescale stage, 32 root stages and FRAC_BITS+3 quotient stages.
// The single row port limits how often items are taken: a new item is not
// accepted while busy is high.
// Reset clears all valid bits and the row serializer; items in flight are
// dropped. The receiver cannot stall, so nothing holds rows back.
module look_at_view_matrix #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [23:0]   req_eye_x,
   input  wire logic signed [23:0]   req_eye_y,
   input  wire logic signed [23:0]   req_eye_z,
   input  wire logic signed [23:0]   req_target_x,
   input  wire logic signed [23:0]   req_target_y,
   input  wire logic signed [23:0]   req_target_z,
   input  wire logic signed [23:0]   req_up_x,
   input  wire logic signed [23:0]   req_up_y,
   input  wire logic signed [23:0]   req_up_z,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_row_index,
   output logic signed [17:0]        rsp_col_x,
   output logic signed [17:0]        rsp_col_y,
   output logic signed [17:0]        rsp_col_z,
   output logic signed [25:0]        rsp_shift,
   output logic                      rsp_last_row
);
   localparam int unsigned LAT1 = 32 + FRAC_BITS + 2 + 2;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   logic acc;
   assign acc = start && !busy;

   // eye/up delay line
   typedef struct packed {
      lav_pkg::coord_type [2:0] eye;
      lav_pkg::coord_type [2:0] up;
   } carry_type;
   carry_type d1_ff [LAT1];
   carry_type d2_ff [LAT1];

   logic signed [63:0] fwd [3];
   always_comb begin
      fwd[0] = 64'(req_target_x) - 64'(req_eye_x);
      fwd[1] = 64'(req_target_y) - 64'(req_eye_y);
      fwd[2] = 64'(req_target_z) - 64'(req_eye_z);
   end

   logic f_v;
   lav_pkg::unit_type f_u;
   lav_norm #(.FRAC_BITS(FRAC_BITS)) u_nf (
      .clock(clock), .reset(reset), .in_valid(acc),
      .in_x(fwd[0]), .in_y(fwd[1]), .in_z(fwd[2]),
      .out_valid(f_v), .out_unit(f_u));

   always_ff @(posedge clock) begin
      d1_ff[0] <= '{eye: {req_eye_z, req_eye_y, req_eye_x},
                    up: {req_up_z, req_up_y, req_up_x}};
      for (int k = 1; k < LAT1; k++) begin
         d1_ff[k] <= d1_ff[k-1];
      end
   end

   // cross F x U, registered
   logic signed [63:0] sr_ff [3];
   lav_pkg::unit_type f1_ff;
   logic sv_ff;
   carry_type c1_ff;
   always_ff @(posedge clock) begin
      sr_ff[0] <= 64'(f_u[1]) * 64'(d1_ff[LAT1-1].up[2])
                - 64'(f_u[2]) * 64'(d1_ff[LAT1-1].up[1]);
      sr_ff[1] <= 64'(f_u[2]) * 64'(d1_ff[LAT1-1].up[0])
                - 64'(f_u[0]) * 64'(d1_ff[LAT1-1].up[2]);
      sr_ff[2] <= 64'(f_u[0]) * 64'(d1_ff[LAT1-1].up[1])
                - 64'(f_u[1]) * 64'(d1_ff[LAT1-1].up[0]);
      f1_ff <= f_u;
      c1_ff <= d1_ff[LAT1-1];
      if (reset) sv_ff <= 1'b0;
      else sv_ff <= f_v;
   end

   logic s_v;
   lav_pkg::unit_type s_u;
   lav_norm #(.FRAC_BITS(FRAC_BITS)) u_ns (
      .clock(clock), .reset(reset), .in_valid(sv_ff),
      .in_x(sr_ff[0]), .in_y(sr_ff[1]), .in_z(sr_ff[2]),
      .out_valid(s_v), .out_unit(s_u));

   lav_pkg::unit_type fd_ff [LAT1];
   always_ff @(posedge clock) begin
      fd_ff[0] <= f1_ff;
      d2_ff[0] <= c1_ff;
      for (int k = 1; k < LAT1; k++) begin
         fd_ff[k] <= fd_ff[k-1];
         d2_ff[k] <= d2_ff[k-1];
      end
   end

   function automatic logic signed [17:0] sat1(input logic signed [63:0] v);
      if (v > ONE) return 18'(ONE);
      if (v < -ONE) return 18'(-ONE);
      return 18'(v);
   endfunction

   function automatic logic signed [63:0] rshr(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[63] ? -64'(m) : 64'(m);
   endfunction

   // stage A: V raw products
   logic signed [63:0] vr_ff [3];
   lav_pkg::col_type [2:0] sa_ff, fa_ff;
   lav_pkg::coord_type [2:0] ea_ff;
   logic va_ff;
   lav_pkg::unit_type fo;
   assign fo = fd_ff[LAT1-1];
   always_ff @(posedge clock) begin
      vr_ff[0] <= 64'(s_u[1]) * 64'(fo[2]) - 64'(s_u[2]) * 64'(fo[1]);
      vr_ff[1] <= 64'(s_u[2]) * 64'(fo[0]) - 64'(s_u[0]) * 64'(fo[2]);
      vr_ff[2] <= 64'(s_u[0]) * 64'(fo[1]) - 64'(s_u[1]) * 64'(fo[0]);
      for (int i = 0; i < 3; i++) begin
         sa_ff[i] <= sat1(64'(s_u[i]));
         fa_ff[i] <= sat1(-64'(fo[i]));
      end
      ea_ff <= d2_ff[LAT1-1].eye;
      if (reset) va_ff <= 1'b0;
      else va_ff <= s_v;
   end

   // stage B: rows final, dot products
   logic signed [2:0][2:0][17:0] rw_ff;
   logic signed [2:0][63:0] dt_ff;
   logic vb_ff;
   lav_pkg::col_type [2:0] vrow;
   always_comb begin
      for (int i = 0; i < 3; i++) vrow[i] = sat1(rshr(vr_ff[i]));
   end
   always_ff @(posedge clock) begin
      rw_ff[0] <= sa_ff;
      rw_ff[1] <= vrow;
      rw_ff[2] <= fa_ff;
      dt_ff[0] <= 64'(sa_ff[0]) * 64'(ea_ff[0]) + 64'(sa_ff[1]) * 64'(ea_ff[1])
                + 64'(sa_ff[2]) * 64'(ea_ff[2]);
      dt_ff[1] <= 64'(vrow[0]) * 64'(ea_ff[0]) + 64'(vrow[1]) * 64'(ea_ff[1])
                + 64'(vrow[2]) * 64'(ea_ff[2]);
      dt_ff[2] <= 64'(fa_ff[0]) * 64'(ea_ff[0]) + 64'(fa_ff[1]) * 64'(ea_ff[1])
                + 64'(fa_ff[2]) * 64'(ea_ff[2]);
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
   end

   function automatic logic signed [25:0] satsh(input logic signed [63:0] d);
      logic signed [63:0] t;
      t = -rshr(d);
      if (t > 64'sd33554431) return 26'sd33554431;
      if (t < -64'sd33554432) return -26'sd33554432;
      return 26'(t);
   endfunction

   // output serializer: one row per cycle
   typedef struct packed {
      logic signed [2:0][2:0][17:0] rw;
      logic signed [2:0][25:0]      sh;
   } mat_type;
   mat_type hold_ff;
   logic [1:0] row_ff;
   logic act_ff;
   logic [1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (vb_ff) begin
         hold_ff.rw <= rw_ff;
         for (int k = 0; k < 3; k++) hold_ff.sh[k] <= satsh(dt_ff[k]);
      end
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= lav_pkg::ROW_SIDE;
      end else if (vb_ff) begin
         act_ff <= 1'b1;
         row_ff <= lav_pkg::ROW_SIDE;
      end else if (act_ff) begin
         if (row_ff == lav_pkg::ROW_FWD) begin
            act_ff <= 1'b0;
            row_ff <= lav_pkg::ROW_SIDE;
         end else begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   // issue gate: holds busy after each accepted item
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 2'd0;
      else if (acc) pend_ff <= 2'd2;
      else if (pend_ff != 2'd0) pend_ff <= pend_ff - 2'd1;
   end
   assign busy = (pend_ff != 2'd0);

   assign rsp_valid = act_ff;
   assign rsp_row_index = row_ff;
   assign rsp_col_x = hold_ff.rw[row_ff][0];
   assign rsp_col_y = hold_ff.rw[row_ff][1];
   assign rsp_col_z = hold_ff.rw[row_ff][2];
   assign rsp_shift = hold_ff.sh[row_ff];
   assign rsp_last_row = act_ff && (row_ff == lav_pkg::ROW_FWD);

`ifndef SYNTHESIS
   a_gap: assert property (@(posedge clock) disable iff (reset)
      acc |=> !acc) else $error("gap");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && row_ff == lav_pkg::ROW_SIDE |=> rsp_valid) else $error("seq");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_last_row |-> rsp_valid) else $error("last");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/lav_norm.sv
`default_nettype none
// Pipelined vector normalizer. Stage 0 prescales and squares, then one
// root bit per stage, then one quotient bit per stage per lane.
module lav_norm #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic signed [63:0]     in_x,
   input  wire logic signed [63:0]     in_y,
   input  wire logic signed [63:0]     in_z,
   output logic                        out_valid,
   output lav_pkg::unit_type           out_unit
);
   localparam int unsigned RS = 32;               // root stages
   localparam int unsigned QB = FRAC_BITS + 2;    // quotient bits
   localparam int unsigned NUM_W = 2 * 24 + 2 + FRAC_BITS + 6 + 2;

   typedef struct packed {
      logic [2:0]        neg;
      logic [2:0][23:0]  mag;
      logic [63:0]       rem;
      logic [63:0]       root;
      logic              zero;
   } sqs_type;

   logic [63:0] ma [3];
   logic [63:0] mor;
   logic [5:0]  sh;
   logic [2:0][23:0] msc;
   logic [63:0] ss;

   always_comb begin
      ma[0] = in_x[63] ? 64'(-in_x) : 64'(in_x);
      ma[1] = in_y[63] ? 64'(-in_y) : 64'(in_y);
      ma[2] = in_z[63] ? 64'(-in_z) : 64'(in_z);
      mor = ma[0] | ma[1] | ma[2];
      sh = '0;
      for (int b = 24; b < 64; b++) begin
         if (mor[b]) begin
            sh = 6'(b - 23);
         end
      end
      for (int i = 0; i < 3; i++) begin
         msc[i] = 24'(ma[i] >> sh);
      end
      ss = 64'(msc[0]) * 64'(msc[0]) + 64'(msc[1]) * 64'(msc[1])
         + 64'(msc[2]) * 64'(msc[2]);
   end

   logic [RS:0]   v_ff;
   sqs_type       s_ff [RS+1];
   sqs_type       s_in [RS+1];
   logic [63:0]   x12;

   assign x12 = ss << 12;

   always_comb begin
      s_in[0].neg = {in_z[63], in_y[63], in_x[63]};
      s_in[0].mag = msc;
      s_in[0].rem = x12;
      s_in[0].root = '0;
      s_in[0].zero = (ss == '0);
      for (int k = 1; k <= RS; k++) begin
         logic [63:0] bb;
         logic [63:0] tr;
         bb = 64'(1) << (2 * (RS - k));
         tr = s_ff[k-1].root + bb;
         s_in[k] = s_ff[k-1];
         // root held as r scaled by the pending bit position
         if (s_ff[k-1].rem >= tr) begin
            s_in[k].rem = s_ff[k-1].rem - tr;
            s_in[k].root = (s_ff[k-1].root >> 1) + bb;
         end else begin
            s_in[k].root = s_ff[k-1].root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= RS; k++) begin
         s_ff[k] <= s_in[k];
      end
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[RS-1:0], in_valid};
      end
   end

   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][NUM_W-1:0]   rem;
      logic [2:0][QB-1:0]      quo;
      logic [NUM_W-1:0]        den;
      logic                    zero;
   } qs_type;

   qs_type     q_ff [QB+1];
   qs_type     q_in [QB+1];
   logic [QB:0] qv_ff;

   always_comb begin
      q_in[0].neg = s_ff[RS].neg;
      q_in[0].zero = s_ff[RS].zero;
      q_in[0].den = NUM_W'({s_ff[RS].root, 1'b0});
      q_in[0].quo = '0;
      for (int i = 0; i < 3; i++) begin
         q_in[0].rem[i] = NUM_W'({NUM_W'(s_ff[RS].mag[i]) << (FRAC_BITS + 7)})
                        + NUM_W'(s_ff[RS].root);
      end
      for (int k = 1; k <= QB; k++) begin
         logic [NUM_W+QB-1:0] dd;
         q_in[k] = q_ff[k-1];
         dd = (NUM_W+QB)'(q_ff[k-1].den) << (QB - k);
         for (int i = 0; i < 3; i++) begin
            if ((NUM_W+QB)'(q_ff[k-1].rem[i]) >= dd) begin
               q_in[k].rem[i] = NUM_W'((NUM_W+QB)'(q_ff[k-1].rem[i]) - dd);
               q_in[k].quo[i][QB-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         q_ff[k] <= q_in[k];
      end
      if (reset) begin
         qv_ff <= '0;
      end else begin
         qv_ff <= {qv_ff[QB-1:0], v_ff[RS]};
      end
   end

   always_comb begin
      out_valid = qv_ff[QB];
      for (int i = 0; i < 3; i++) begin
         logic signed [lav_pkg::QUO_W:0] qs;
         qs = (lav_pkg::QUO_W+1)'(q_ff[QB].quo[i]);
         if (q_ff[QB].zero) begin
            out_unit[i] = '0;
         end else begin
            out_unit[i] = q_ff[QB].neg[i] ? -qs : qs;
         end
      end
   end

`ifndef SYNTHESIS
   a_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && q_ff[QB].zero |-> out_unit[0] == '0) else $error("zero");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid && !q_ff[QB].zero |-> q_ff[QB].quo[0] <= QB'(1) << FRAC_BITS)
      else $error("bound");
   a_vld: assert property (@(posedge clock) disable iff (reset)
      v_ff[RS] |=> qv_ff[0]) else $error("valid");
`endif
endmodule
`default_nettype wire
